FILE: hw/rtl/wsc_pkg.sv
// Shared constants and types of the spectral color map.
`default_nettype none

package wsc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int POS_W         = 17;
  localparam int LEVEL_W       = 8;
  // 400 * position needs nine more bits than the position itself
  localparam int P400_W        = POS_W + 9;
  localparam int DIV_W         = 7;

  typedef enum logic [1:0] {
    LM_ZERO,
    LM_ONE,
    LM_RAMP
  } lvl_mode_t;

  typedef struct packed {
    lvl_mode_t red;
    lvl_mode_t green;
    lvl_mode_t blue;
    lvl_mode_t inten;
  } mode_set_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wavelength_spectrum_color_unit.sv
// Spectral color map: position in [0,1] to scaled red, green and blue bytes.
`default_nettype none

// One position beat in, one color beat out, in order. The pipeline has six
// register stages, and a new position is taken in every cycle while the
// result side keeps up. Stage one forms the wavelength offset dw = 400 * t,
// stage two finds the spectral segment and builds the two ramp numerators
// (one color ramp and the intensity ramp), stage three multiplies them by
// reciprocals of the segment spans, stage four fixes the quotients by one
// compare-and-subtract and picks the levels, stage five multiplies level by
// intensity and stage six scales by 255, rounds half up and holds the
// output byte. A stall on out_ready freezes every stage at once; in_ready
// follows it in the same cycle. Positions above 1.0 give black.
module wavelength_spectrum_color_unit #(
  parameter int FRACTION_BITS = wsc_pkg::FRACTION_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [wsc_pkg::POS_W-1:0]    in_position,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [wsc_pkg::LEVEL_W-1:0]       out_red_level,
  output logic [wsc_pkg::LEVEL_W-1:0]       out_green_level,
  output logic [wsc_pkg::LEVEL_W-1:0]       out_blue_level
);

  localparam int FB     = FRACTION_BITS;
  localparam int DW_W   = FB + 10;            // dw up to 800 nm-units with fraction
  localparam int NW     = FB + 7;             // ramp numerators, at most 65 * 2^FB
  localparam int LW     = FB + 1;             // level and intensity, Q1.FB
  localparam int PW2    = 2 * LW;
  localparam int SW     = PW2 + 8;            // product times 255
  localparam int SH_UP  = (FB >= 16) ? FB - 16 : 0;
  localparam int SH_DN  = (FB < 16) ? 16 - FB : 0;
  localparam int EXT_W  = wsc_pkg::P400_W + SH_UP;
  localparam int DV     = wsc_pkg::DIV_W;
  localparam int LV     = wsc_pkg::LEVEL_W;

  // Break points as offsets from 380 nm, in dw units
  localparam logic [DW_W-1:0] T40  = DW_W'(40)  << FB;
  localparam logic [DW_W-1:0] T60  = DW_W'(60)  << FB;
  localparam logic [DW_W-1:0] T110 = DW_W'(110) << FB;
  localparam logic [DW_W-1:0] T130 = DW_W'(130) << FB;
  localparam logic [DW_W-1:0] T200 = DW_W'(200) << FB;
  localparam logic [DW_W-1:0] T265 = DW_W'(265) << FB;
  localparam logic [DW_W-1:0] T320 = DW_W'(320) << FB;
  localparam logic [DW_W-1:0] T400 = DW_W'(400) << FB;
  localparam logic [DW_W-1:0] T800 = DW_W'(800) << FB;

  localparam logic [LW-1:0]   ONE_L = LW'(1) << FB;
  localparam logic [SW-1:0]   HALF  = SW'(1) << (2 * FB - 1);

  // Spans after stripping their power-of-two factor
  localparam logic [DV-1:0] D5  = DV'(5);
  localparam logic [DV-1:0] D15 = DV'(15);
  localparam logic [DV-1:0] D25 = DV'(25);
  localparam logic [DV-1:0] D35 = DV'(35);
  localparam logic [DV-1:0] D65 = DV'(65);

  // floor(2^NW / d): the product quotient is exact or one low
  localparam logic [NW-1:0] REC5  = NW'((64'd1 << NW) / 64'd5);
  localparam logic [NW-1:0] REC15 = NW'((64'd1 << NW) / 64'd15);
  localparam logic [NW-1:0] REC25 = NW'((64'd1 << NW) / 64'd25);
  localparam logic [NW-1:0] REC35 = NW'((64'd1 << NW) / 64'd35);
  localparam logic [NW-1:0] REC65 = NW'((64'd1 << NW) / 64'd65);

  function automatic logic [LW-1:0] pick_level(input wsc_pkg::lvl_mode_t mode,
                                               input logic [LW-1:0] ramp);
    logic [LW-1:0] v;
    case (mode)
      wsc_pkg::LM_ONE:  v = ONE_L;
      wsc_pkg::LM_RAMP: v = ramp;
      default:          v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [LV-1:0] round_byte(input logic [PW2-1:0] prod);
    logic [SW-1:0] x;
    x = (SW'(prod) << 8) - SW'(prod) + HALF;
    return x[2 * FB +: LV];
  endfunction

  // One enable for the whole pipe: advance when the output slot is free
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: wavelength offset ----------------
  logic [wsc_pkg::P400_W-1:0] p400;
  logic [DW_W-1:0]            dw_nxt;
  logic [DW_W-1:0]            dw_r;
  logic                       v1_r;

  always_comb begin
    p400   = wsc_pkg::P400_W'(in_position) * wsc_pkg::P400_W'(400);
    dw_nxt = DW_W'((EXT_W'(p400) << SH_UP) >> SH_DN);
  end

  // ---------------- stage 2: segment decode ----------------
  wsc_pkg::mode_set_t mode_nxt, mode2_r;
  logic [NW-1:0]      lnum_nxt, lnum2_r;
  logic [DV-1:0]      ldiv_nxt, ldiv2_r;
  logic [NW-1:0]      lrec_nxt, lrec2_r;
  logic [NW-1:0]      inum_nxt, inum2_r;
  logic               v2_r;

  always_comb begin
    mode_nxt = '{red: wsc_pkg::LM_ZERO, green: wsc_pkg::LM_ZERO,
                 blue: wsc_pkg::LM_ZERO, inten: wsc_pkg::LM_ZERO};
    lnum_nxt = '0;
    ldiv_nxt = D15;
    lrec_nxt = REC15;
    inum_nxt = '0;

    if (dw_r < T60) begin
      // violet: red falls, blue full; span 60 = 4 * 15
      mode_nxt.red  = wsc_pkg::LM_RAMP;
      mode_nxt.blue = wsc_pkg::LM_ONE;
      lnum_nxt      = NW'((T60 - dw_r) >> 2);
      ldiv_nxt      = D15;
      lrec_nxt      = REC15;
    end else if (dw_r < T110) begin
      mode_nxt.green = wsc_pkg::LM_RAMP;
      mode_nxt.blue  = wsc_pkg::LM_ONE;
      lnum_nxt       = NW'((dw_r - T60) >> 1);
      ldiv_nxt       = D25;
      lrec_nxt       = REC25;
    end else if (dw_r < T130) begin
      mode_nxt.green = wsc_pkg::LM_ONE;
      mode_nxt.blue  = wsc_pkg::LM_RAMP;
      lnum_nxt       = NW'((T130 - dw_r) >> 2);
      ldiv_nxt       = D5;
      lrec_nxt       = REC5;
    end else if (dw_r < T200) begin
      mode_nxt.red   = wsc_pkg::LM_RAMP;
      mode_nxt.green = wsc_pkg::LM_ONE;
      lnum_nxt       = NW'((dw_r - T130) >> 1);
      ldiv_nxt       = D35;
      lrec_nxt       = REC35;
    end else if (dw_r < T265) begin
      mode_nxt.red   = wsc_pkg::LM_ONE;
      mode_nxt.green = wsc_pkg::LM_RAMP;
      lnum_nxt       = NW'(T265 - dw_r);
      ldiv_nxt       = D65;
      lrec_nxt       = REC65;
    end else if (dw_r <= T400) begin
      mode_nxt.red = wsc_pkg::LM_ONE;
    end

    // intensity: both ramps reduce to a divide by 25 after a shift
    if (dw_r < T40) begin
      mode_nxt.inten = wsc_pkg::LM_RAMP;
      inum_nxt       = NW'((T60 + dw_r) >> 2);
    end else if (dw_r <= T320) begin
      mode_nxt.inten = wsc_pkg::LM_ONE;
    end else if (dw_r <= T400) begin
      // (3040 - 7 dw) / 800 rewritten around 700 nm to stay narrow
      mode_nxt.inten = wsc_pkg::LM_RAMP;
      inum_nxt       = NW'((T800 - DW_W'(7) * (dw_r - T320)) >> 5);
    end
  end

  // ---------------- stage 3: reciprocal multiply ----------------
  logic [2*NW-1:0]    lprod, iprod;
  logic [LW-1:0]      lq3_r, iq3_r;
  logic [NW-1:0]      lnum3_r, inum3_r;
  logic [DV-1:0]      ldiv3_r;
  wsc_pkg::mode_set_t mode3_r;
  logic               v3_r;

  always_comb begin
    lprod = (2 * NW)'(lnum2_r) * (2 * NW)'(lrec2_r);
    iprod = (2 * NW)'(inum2_r) * (2 * NW)'(REC25);
  end

  // ---------------- stage 4: quotient correction, level select ----------------
  logic [NW-1:0] lrem, irem, lrem_fix;
  logic [LW-1:0] lq, iq;
  logic [LW-1:0] red4_r, green4_r, blue4_r, int4_r;
  logic          v4_r;

  always_comb begin
    lrem     = lnum3_r - NW'(lq3_r) * NW'(ldiv3_r);
    irem     = inum3_r - NW'(iq3_r) * NW'(D25);
    lq       = (lrem >= NW'(ldiv3_r)) ? lq3_r + LW'(1) : lq3_r;
    iq       = (irem >= NW'(D25)) ? iq3_r + LW'(1) : iq3_r;
    lrem_fix = (lrem >= NW'(ldiv3_r)) ? lrem - NW'(ldiv3_r) : lrem;
  end

  // ---------------- stage 5: level times intensity ----------------
  logic [PW2-1:0] red5_r, green5_r, blue5_r;
  logic           v5_r;

  // ---------------- stage 6: scale, round, hold ----------------
  logic [LV-1:0]  red6_r, green6_r, blue6_r;
  logic           v6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dw_r     <= dw_nxt;

      mode2_r  <= mode_nxt;
      lnum2_r  <= lnum_nxt;
      ldiv2_r  <= ldiv_nxt;
      lrec2_r  <= lrec_nxt;
      inum2_r  <= inum_nxt;

      lq3_r    <= LW'(lprod >> NW);
      iq3_r    <= LW'(iprod >> NW);
      lnum3_r  <= lnum2_r;
      inum3_r  <= inum2_r;
      ldiv3_r  <= ldiv2_r;
      mode3_r  <= mode2_r;

      red4_r   <= pick_level(mode3_r.red, lq);
      green4_r <= pick_level(mode3_r.green, lq);
      blue4_r  <= pick_level(mode3_r.blue, lq);
      int4_r   <= pick_level(mode3_r.inten, iq);

      red5_r   <= PW2'(red4_r) * PW2'(int4_r);
      green5_r <= PW2'(green4_r) * PW2'(int4_r);
      blue5_r  <= PW2'(blue4_r) * PW2'(int4_r);

      red6_r   <= round_byte(red5_r);
      green6_r <= round_byte(green5_r);
      blue6_r  <= round_byte(blue5_r);
    end
  end

  assign out_valid       = v6_r;
  assign out_red_level   = red6_r;
  assign out_green_level = green6_r;
  assign out_blue_level  = blue6_r;

  // Corrected ramp quotient leaves a remainder below the span
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (lrem_fix < NW'(ldiv3_r)))
    else $error("ramp quotient correction out of range");

  // Levels and intensity never exceed 1.0 going into the multiply
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && $past(adv) |-> (red4_r <= ONE_L) && (green4_r <= ONE_L) &&
                           (blue4_r <= ONE_L) && (int4_r <= ONE_L))
    else $error("level or intensity above one");

  // At most one color channel ramps in any segment
  a_one_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> $onehot0({mode3_r.red == wsc_pkg::LM_RAMP,
                       mode3_r.green == wsc_pkg::LM_RAMP,
                       mode3_r.blue == wsc_pkg::LM_RAMP}))
    else $error("more than one ramping channel");

  // An accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted beat lost at pipe entry");

endmodule

`default_nettype wire
